>>> rtl/tsc_pkg.sv
package tsc_pkg;

   typedef enum logic [2:0] {
      PH_STATS  = 3'd0,
      PH_SOUND  = 3'd1,
      PH_BUTTON = 3'd2,
      PH_COUNT  = 3'd3,
      PH_HOLD   = 3'd4,
      PH_RES    = 3'd5,
      PH_CAL    = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_AVG,
      S_CAL,
      S_T10,
      S_SEC,
      S_MIN,
      S_EMIT
   } seq_type;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_SHORT = 2'd1;
   localparam logic [1:0] MODE_LONG  = 2'd2;
   localparam logic [1:0] MODE_AUDIO = 2'd3;

   localparam logic [1:0] CSR_HOLD   = 2'd0;
   localparam logic [1:0] CSR_GUARD  = 2'd1;
   localparam logic [1:0] CSR_OFFSET = 2'd2;

   localparam int TICK_W    = 24;
   localparam int HOLD_W    = 12;
   localparam int CAL_SUM_W = 12;
   localparam int CAL_CNT_W = 4;
   localparam int DIV_W     = 31;  // lap sum: 24 bits plus 7 for up to 127 slots
   localparam int DVS_W     = 7;

   // time split by reciprocal multiplication, exact over the saturated tick range
   localparam int QUO_W       = 20;  // tick_count / 10
   localparam int Q60_W       = 14;  // tick_count / 600
   localparam int RECIP60_W   = 21;
   localparam int TEN_SHIFT   = 27;
   localparam int SIXTY_SHIFT = 26;
   localparam int CAL_SHIFT   = 16;

   localparam int LAP_SLOTS_DEF     = 5;
   localparam int CALIB_SAMPLES_DEF = 10;

   localparam logic [TICK_W-1:0] ELAPSED_MAX  = 24'd9215999;
   localparam logic [HOLD_W-1:0] HOLD_MAX     = 12'hFFF;
   localparam logic [7:0]        THRESH_RESET = 8'hB0;
   localparam logic [7:0]        OFFSET_RESET = 8'h20;
   localparam logic [7:0]        HOLD_RESET   = 8'd3;
   localparam logic [7:0]        GUARD_RESET  = 8'd5;
   localparam logic [1:0]        PREC_RESET   = 2'd1;
   localparam logic [1:0]        PREC_WHOLE   = 2'd0;
   localparam logic [1:0]        PREC_HALF    = 2'd1;
   localparam logic [1:0]        PREC_TENTH   = 2'd2;
   localparam logic [DVS_W-1:0]  DIV_TEN      = 7'd10;
   localparam logic [DVS_W-1:0]  DIV_SIXTY    = 7'd60;
   localparam logic [TICK_W-1:0]    RECIP_TEN   = 24'hCCCCCD;  // ceil(2^27 / 10)
   localparam logic [RECIP60_W-1:0] RECIP_SIXTY = 21'h111112;  // ceil(2^26 / 60)

endpackage

>>> rtl/tsc_lap_mem.sv
module tsc_lap_mem
   import tsc_pkg::*;
#(
   parameter int LAP_SLOTS = LAP_SLOTS_DEF,
   parameter int AW        = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [TICK_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [TICK_W-1:0] rd_data
);

   logic [TICK_W-1:0]    mem [LAP_SLOTS];
   logic [LAP_SLOTS-1:0] vld_ff;
   logic [TICK_W-1:0]    rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   // unwritten slots read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tsc_div.sv
module tsc_div
   import tsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   // restoring, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/trigger_stopwatch_controller_core.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    mode, sample
// rsp_      out        rsp_valid/rsp_ready    phase, elapsed, h:m:s, tenths, lap stats, status
// csr_      in         csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// One transaction at a time. Each transaction runs the update, a scan of the lap memory
// (one read port), the lap average on the radix-2 divider (skipped when no lap is stored),
// the calibration mean when a calibration completes, the time split into tenths, seconds,
// minutes and hours, and the load of the output register.
// Reset is synchronous; lap slots read as zero until written. A held result stalls only
// the final load; req_ready is high whenever the sequencer is idle.
module trigger_stopwatch_controller_core
   import tsc_pkg::*;
#(
   parameter int LAP_SLOTS     = LAP_SLOTS_DEF,
   parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_mode,
   input  logic [7:0]        req_sample,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_phase,
   output logic [TICK_W-1:0] rsp_elapsed,
   output logic [7:0]        rsp_hours,
   output logic [5:0]        rsp_minutes,
   output logic [5:0]        rsp_seconds,
   output logic [3:0]        rsp_tenths_shown,
   output logic [TICK_W-1:0] rsp_lap_average,
   output logic [TICK_W-1:0] rsp_lap_extreme,
   output logic              rsp_shows_minimum,
   output logic [1:0]        rsp_resolution,
   output logic [7:0]        rsp_trigger_level,
   output logic              rsp_sound_started,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data
);

   localparam int AW = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;
   localparam int CW = $clog2(LAP_SLOTS + 1);
   localparam logic [CAL_CNT_W-1:0] CAL_N = CAL_CNT_W'(CALIB_SAMPLES);
   localparam int CAL_RECIP_W = CAL_SHIFT + 1;
   // ceil(2^16 / CALIB_SAMPLES), exact for any 12-bit sample sum
   localparam logic [CAL_RECIP_W-1:0] CAL_RECIP =
      CAL_RECIP_W'(((1 << CAL_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES);

   // config
   logic [7:0] hold_sec_ff, guard_ff, coff_ff;

   // block state
   phase_type             phase_ff, phase_in;
   logic                  sound_ff, sound_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [HOLD_W-1:0]     hold_ff, hold_in;
   logic [AW-1:0]         wr_idx_ff, wr_idx_in;
   logic                  minv_ff, minv_in;
   logic [1:0]            prec_ff, prec_in;
   logic [7:0]            thr_ff, thr_in;
   logic [CAL_CNT_W-1:0]  ctaken_ff, ctaken_in;
   logic [CAL_SUM_W-1:0]  csum_ff, csum_in;
   logic                  calib_ff, calib_in;
   logic                  cal_pend_ff, cal_pend_in;
   logic [CAL_SUM_W-1:0]  cal_src_ff, cal_src_in;

   // sequencer
   seq_type               seq_ff, seq_in;
   logic [CW-1:0]         rd_idx_ff;
   logic                  rd_vld_ff;
   logic [DIV_W-1:0]      sum_ff;
   logic [DVS_W-1:0]      nz_ff;
   logic [TICK_W-1:0]     mx_ff, mn_ff, avg_ff;
   logic                  issued_ff;
   logic [QUO_W-1:0]      quo_ff;
   logic [3:0]            ms_ff;
   logic [5:0]            sec_ff, min_ff;
   logic [7:0]            hr_ff;

   logic                  rsp_valid_ff;

   logic                  req_acc, rd_en, div_start, rsp_load, lap_we;
   logic                  div_done;
   logic [DIV_W-1:0]      div_q;
   logic [TICK_W-1:0]     rd_data;
   logic [HOLD_W-1:0]     hs10, hold_inc;
   logic [CAL_SUM_W-1:0]  csum_new;
   logic [CAL_CNT_W-1:0]  ctaken_new;
   logic                  ev_tick, ev_short, ev_long, ev_audio, loud;
   logic [3:0]            tenths;

   logic [2*TICK_W-1:0]            t10_prod;
   logic [QUO_W-1:0]               t10_q;
   logic [TICK_W-1:0]              t10_rem;
   logic [QUO_W+RECIP60_W-1:0]     s60_prod;
   logic [Q60_W-1:0]               s60_q;
   logic [QUO_W-1:0]               s60_rem;
   logic [CAL_SUM_W+CAL_RECIP_W-1:0] cal_prod;
   logic [7:0]                     cal_mean;

   assign req_acc = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_sec_ff <= HOLD_RESET;
         guard_ff    <= GUARD_RESET;
         coff_ff     <= OFFSET_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HOLD:   hold_sec_ff <= csr_data;
            CSR_GUARD:  guard_ff    <= csr_data;
            CSR_OFFSET: coff_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // quotient and remainder by constants, one step per sequencer state
   always_comb begin
      t10_prod = tick_ff * RECIP_TEN;
      t10_q    = t10_prod[TEN_SHIFT +: QUO_W];
      t10_rem  = tick_ff - TICK_W'(t10_q) * TICK_W'(DIV_TEN);
      s60_prod = quo_ff * RECIP_SIXTY;
      s60_q    = s60_prod[SIXTY_SHIFT +: Q60_W];
      s60_rem  = quo_ff - QUO_W'(s60_q) * QUO_W'(DIV_SIXTY);
      cal_prod = cal_src_ff * CAL_RECIP;
      cal_mean = cal_prod[CAL_SHIFT +: 8];
   end

   // ---------------- per-event update ----------------
   always_comb begin
      ev_tick    = (req_mode == MODE_TICK);
      ev_short   = (req_mode == MODE_SHORT);
      ev_long    = (req_mode == MODE_LONG);
      ev_audio   = (req_mode == MODE_AUDIO);
      loud       = ev_audio && (req_sample > thr_ff);
      hs10       = HOLD_W'(hold_sec_ff) * HOLD_W'(10);
      hold_inc   = (hold_ff < HOLD_MAX) ? hold_ff + HOLD_W'(1) : hold_ff;
      csum_new   = csum_ff + CAL_SUM_W'(req_sample);
      ctaken_new = ctaken_ff + CAL_CNT_W'(1);

      phase_in    = phase_ff;
      sound_in    = sound_ff;
      tick_in     = tick_ff;
      hold_in     = hold_ff;
      wr_idx_in   = wr_idx_ff;
      minv_in     = minv_ff;
      prec_in     = prec_ff;
      thr_in      = thr_ff;
      ctaken_in   = ctaken_ff;
      csum_in     = csum_ff;
      calib_in    = calib_ff;
      cal_pend_in = cal_pend_ff;
      cal_src_in  = cal_src_ff;
      lap_we      = 1'b0;

      if (req_acc) begin
         unique case (phase_ff)
            PH_STATS: begin
               if (ev_short) minv_in = !minv_ff;
               else if (ev_long) phase_in = PH_SOUND;
            end
            PH_SOUND: begin
               if (loud) begin
                  sound_in = 1'b1;
                  tick_in  = '0;
                  phase_in = PH_COUNT;
               end else if (ev_long) begin
                  phase_in = PH_BUTTON;
               end
            end
            PH_BUTTON: begin
               if (ev_short) begin
                  sound_in = 1'b0;
                  tick_in  = '0;
                  phase_in = PH_COUNT;
               end else if (ev_long) begin
                  phase_in = PH_RES;
               end
            end
            PH_COUNT: begin
               if (ev_tick) begin
                  if (tick_ff < ELAPSED_MAX) tick_in = tick_ff + TICK_W'(1);
               end else if (ev_short ||
                            (loud && sound_ff && tick_ff >= TICK_W'(guard_ff))) begin
                  lap_we    = 1'b1;
                  wr_idx_in = (wr_idx_ff == AW'(LAP_SLOTS - 1)) ? '0 : wr_idx_ff + AW'(1);
                  hold_in   = '0;
                  if (hold_sec_ff == 8'd0) phase_in = sound_ff ? PH_SOUND : PH_BUTTON;
                  else phase_in = PH_HOLD;
               end
            end
            PH_HOLD: begin
               if (ev_tick) begin
                  hold_in = hold_inc;
                  if (hold_inc >= hs10) phase_in = sound_ff ? PH_SOUND : PH_BUTTON;
               end
            end
            PH_RES: begin
               if (ev_short) prec_in = (prec_ff == PREC_TENTH) ? PREC_WHOLE : prec_ff + 2'd1;
               else if (ev_long) phase_in = PH_CAL;
            end
            PH_CAL: begin
               if (!calib_ff) begin
                  if (ev_long) begin
                     phase_in = PH_STATS;
                  end else if (ev_short) begin
                     calib_in  = 1'b1;
                     ctaken_in = '0;
                     csum_in   = '0;
                  end
               end else if (ctaken_ff < CAL_N) begin
                  if (ev_audio) begin
                     csum_in   = csum_new;
                     ctaken_in = ctaken_new;
                     if (ctaken_new >= CAL_N) begin
                        cal_pend_in = 1'b1;
                        cal_src_in  = csum_new;
                        hold_in     = '0;
                        if (hold_sec_ff == 8'd0) begin
                           calib_in  = 1'b0;
                           ctaken_in = '0;
                           csum_in   = '0;
                           phase_in  = PH_STATS;
                        end
                     end
                  end
               end else if (ev_tick) begin
                  hold_in = hold_inc;
                  if (hold_inc >= hs10) begin
                     calib_in  = 1'b0;
                     ctaken_in = '0;
                     csum_in   = '0;
                     phase_in  = PH_STATS;
                  end
               end
            end
            default: ;
         endcase
      end

      // new trigger level from the calibration mean, before the result is loaded
      if (seq_ff == S_CAL) begin
         thr_in      = cal_mean + coff_ff;
         cal_pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_STATS;
         sound_ff    <= 1'b0;
         tick_ff     <= '0;
         hold_ff     <= '0;
         wr_idx_ff   <= '0;
         minv_ff     <= 1'b0;
         prec_ff     <= PREC_RESET;
         thr_ff      <= THRESH_RESET;
         ctaken_ff   <= '0;
         csum_ff     <= '0;
         calib_ff    <= 1'b0;
         cal_pend_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         sound_ff    <= sound_in;
         tick_ff     <= tick_in;
         hold_ff     <= hold_in;
         wr_idx_ff   <= wr_idx_in;
         minv_ff     <= minv_in;
         prec_ff     <= prec_in;
         thr_ff      <= thr_in;
         ctaken_ff   <= ctaken_in;
         csum_ff     <= csum_in;
         calib_ff    <= calib_in;
         cal_pend_ff <= cal_pend_in;
      end
      cal_src_ff <= cal_src_in;
   end

   // ---------------- sequencer ----------------
   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         S_IDLE: if (req_acc) seq_in = S_SCAN;
         S_SCAN: if (rd_idx_ff == CW'(LAP_SLOTS) && !rd_vld_ff) seq_in = S_AVG;
         S_AVG:  if (nz_ff == '0 || div_done) seq_in = cal_pend_ff ? S_CAL : S_T10;
         S_CAL:  seq_in = S_T10;
         S_T10:  seq_in = S_SEC;
         S_SEC:  seq_in = S_MIN;
         S_MIN:  seq_in = S_EMIT;
         S_EMIT: if (!rsp_valid_ff || rsp_ready) seq_in = S_IDLE;
         default: seq_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rsp_load  = 1'b0;
      unique case (seq_ff)
         S_IDLE: req_ready = 1'b1;
         S_SCAN: rd_en = (rd_idx_ff != CW'(LAP_SLOTS));
         S_EMIT: rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
      div_start = !issued_ff && seq_ff == S_AVG && nz_ff != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= S_IDLE;
         rd_vld_ff <= 1'b0;
         issued_ff <= 1'b0;
      end else begin
         seq_ff    <= seq_in;
         rd_vld_ff <= rd_en;
         if (div_start) issued_ff <= 1'b1;
         else if (div_done) issued_ff <= 1'b0;
      end
   end

   // scan accumulators, average and time split
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_idx_ff <= '0;
         sum_ff    <= '0;
         nz_ff     <= '0;
         mx_ff     <= '0;
         mn_ff     <= '0;
      end else begin
         if (rd_en) rd_idx_ff <= rd_idx_ff + CW'(1);
         if (rd_vld_ff) begin
            sum_ff <= sum_ff + DIV_W'(rd_data);
            if (rd_data != '0) begin
               nz_ff <= nz_ff + DVS_W'(1);
               if (mn_ff == '0 || rd_data < mn_ff) mn_ff <= rd_data;
            end
            if (rd_data > mx_ff) mx_ff <= rd_data;
         end
      end
      if (seq_ff == S_AVG) begin
         if (nz_ff == '0) avg_ff <= '0;
         else if (div_done) avg_ff <= div_q[TICK_W-1:0];
      end
      case (seq_ff)
         S_T10: begin
            ms_ff  <= t10_rem[3:0];
            quo_ff <= t10_q;
         end
         S_SEC: begin
            sec_ff <= s60_rem[5:0];
            quo_ff <= QUO_W'(s60_q);
         end
         S_MIN: begin
            min_ff <= s60_rem[5:0];
            hr_ff  <= s60_q[7:0];
         end
         default: ;
      endcase
   end

   always_comb begin
      case (prec_ff)
         PREC_WHOLE: tenths = 4'd0;
         PREC_HALF:  tenths = (ms_ff > 4'd5) ? 4'd5 : 4'd0;
         default:    tenths = ms_ff;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_phase         <= phase_ff;
         rsp_elapsed       <= tick_ff;
         rsp_hours         <= hr_ff;
         rsp_minutes       <= min_ff;
         rsp_seconds       <= sec_ff;
         rsp_tenths_shown  <= tenths;
         rsp_lap_average   <= avg_ff;
         rsp_lap_extreme   <= minv_ff ? mn_ff : mx_ff;
         rsp_shows_minimum <= minv_ff;
         rsp_resolution    <= prec_ff;
         rsp_trigger_level <= thr_ff;
         rsp_sound_started <= sound_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   tsc_lap_mem #(
      .LAP_SLOTS (LAP_SLOTS),
      .AW        (AW)
   ) u_lap_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (lap_we),
      .wr_addr (wr_idx_ff),
      .wr_data (tick_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   tsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (nz_ff),
      .done     (div_done),
      .quotient (div_q)
   );

endmodule

>>> rtl/tsc_checker.sv
module tsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_elapsed,
   input logic [5:0]  rsp_minutes,
   input logic [5:0]  rsp_seconds,
   input logic [3:0]  rsp_tenths_shown,
   input logic [1:0]  rsp_resolution
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_elapsed))
      else $error("result changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while busy");

   a_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_minutes < 6'd60 && rsp_seconds < 6'd60 && rsp_tenths_shown < 4'd10)
      else $error("time split out of range");

   a_whole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_resolution == 2'd0 |-> rsp_tenths_shown == 4'd0)
      else $error("tenths shown at whole-second resolution");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_elapsed <= 24'd9215999)
      else $error("elapsed beyond saturation");

endmodule

bind trigger_stopwatch_controller_core tsc_checker u_tsc_checker (.*);

>>> dv/trigger_stopwatch_controller_core_checker.sv
`timescale 1ns / 100ps
module trigger_stopwatch_controller_core_checker
   import tsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_sample,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_phase,
   input  logic [23:0] rsp_elapsed,
   input  logic [7:0]  rsp_hours,
   input  logic [5:0]  rsp_minutes,
   input  logic [5:0]  rsp_seconds,
   input  logic [3:0]  rsp_tenths_shown,
   input  logic [23:0] rsp_lap_average,
   input  logic [23:0] rsp_lap_extreme,
   input  logic        rsp_shows_minimum,
   input  logic [1:0]  rsp_resolution,
   input  logic [7:0]  rsp_trigger_level,
   input  logic        rsp_sound_started,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          errors
);

   localparam int SLOTS   = LAP_SLOTS_DEF;
   localparam int SAMPLES = CALIB_SAMPLES_DEF;

   typedef struct {
      logic [2:0]  phase;
      logic [23:0] elapsed;
      logic [7:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
      logic [3:0]  tenths;
      logic [23:0] average;
      logic [23:0] extreme;
      logic        min_view;
      logic [1:0]  resolution;
      logic [7:0]  trigger;
      logic        by_sound;
   } display_type;

   display_type display_q[$];

   logic [7:0]  hold_secs, guard, offset;
   phase_type   phase;
   logic        by_sound, min_view, calibrating;
   logic [23:0] ticks;
   logic [11:0] hold_cnt;
   logic [23:0] laps[SLOTS];
   int          lap_ptr;
   logic [1:0]  prec;
   logic [7:0]  thresh;
   int          cal_cnt;
   int          cal_sum;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   task automatic stop_run();
      laps[lap_ptr] = ticks;
      lap_ptr = (lap_ptr + 1) % SLOTS;
      hold_cnt = '0;
      phase = PH_HOLD;
      if (hold_secs == 0) phase = by_sound ? PH_SOUND : PH_BUTTON;
   endtask

   task automatic end_calibration();
      calibrating = 0;
      cal_cnt = 0;
      cal_sum = 0;
      phase = PH_STATS;
   endtask

   task automatic step_display(input logic [1:0] mode, input logic [7:0] smp,
                               output display_type d);
      longint sum;
      int     nz;
      logic [23:0] mx, mn, t;
      int     ms;
      sum = 0; nz = 0; mx = '0; mn = '0;
      case (phase)
         PH_STATS: begin
            if (mode == MODE_SHORT) min_view = ~min_view;
            else if (mode == MODE_LONG) phase = PH_SOUND;
         end
         PH_SOUND: begin
            if (mode == MODE_AUDIO && smp > thresh) begin
               by_sound = 1; ticks = '0; phase = PH_COUNT;
            end else if (mode == MODE_LONG) phase = PH_BUTTON;
         end
         PH_BUTTON: begin
            if (mode == MODE_SHORT) begin
               by_sound = 0; ticks = '0; phase = PH_COUNT;
            end else if (mode == MODE_LONG) phase = PH_RES;
         end
         PH_COUNT: begin
            if (mode == MODE_TICK) begin
               if (ticks < ELAPSED_MAX) ticks++;
            end else if (mode == MODE_SHORT) stop_run();
            else if (mode == MODE_AUDIO && by_sound && smp > thresh && ticks >= guard)
               stop_run();
         end
         PH_HOLD: begin
            if (mode == MODE_TICK) begin
               if (hold_cnt < HOLD_MAX) hold_cnt++;
               if (hold_cnt >= hold_secs * 10) phase = by_sound ? PH_SOUND : PH_BUTTON;
            end
         end
         PH_RES: begin
            if (mode == MODE_SHORT) prec = (prec == PREC_TENTH) ? PREC_WHOLE : prec + 2'd1;
            else if (mode == MODE_LONG) phase = PH_CAL;
         end
         default: begin
            if (!calibrating) begin
               if (mode == MODE_LONG) phase = PH_STATS;
               else if (mode == MODE_SHORT) begin
                  calibrating = 1; cal_cnt = 0; cal_sum = 0;
               end
            end else if (cal_cnt < SAMPLES) begin
               if (mode == MODE_AUDIO) begin
                  cal_sum += smp;
                  cal_cnt++;
                  if (cal_cnt >= SAMPLES) begin
                     thresh = 8'((cal_sum / SAMPLES) + offset);
                     hold_cnt = '0;
                     if (hold_secs == 0) end_calibration();
                  end
               end
            end else if (mode == MODE_TICK) begin
               if (hold_cnt < HOLD_MAX) hold_cnt++;
               if (hold_cnt >= hold_secs * 10) end_calibration();
            end
         end
      endcase

      foreach (laps[i]) begin
         sum += laps[i];
         if (laps[i] != 0) begin
            nz++;
            if (mn == 0 || laps[i] < mn) mn = laps[i];
         end
         if (laps[i] > mx) mx = laps[i];
      end
      t = ticks;
      ms = t % 10;
      if (prec == PREC_WHOLE) ms = 0;
      else if (prec == PREC_HALF) ms = (ms > 5) ? 5 : 0;

      d.phase = phase;
      d.elapsed = t;
      d.hours = 8'(t / 36000);
      d.minutes = 6'((t / 600) % 60);
      d.seconds = 6'((t / 10) % 60);
      d.tenths = 4'(ms);
      d.average = nz ? 24'(sum / nz) : '0;
      d.extreme = min_view ? mn : mx;
      d.min_view = min_view;
      d.resolution = prec;
      d.trigger = thresh;
      d.by_sound = by_sound;
   endtask

   always @(posedge clock) begin
      display_type d, e;
      if (reset) begin
         hold_secs = HOLD_RESET; guard = GUARD_RESET; offset = OFFSET_RESET;
         phase = PH_STATS; by_sound = 0; ticks = '0; hold_cnt = '0;
         foreach (laps[i]) laps[i] = '0;
         lap_ptr = 0; min_view = 0; prec = PREC_RESET; thresh = THRESH_RESET;
         cal_cnt = 0; cal_sum = 0; calibrating = 0;
         display_q.delete();
         errors = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (display_q.size() == 0) begin
               $display("%0t unexpected transaction on result channel", $time);
               errors++;
            end else begin
               e = display_q.pop_front();
               if (rsp_phase !== e.phase) report("phase", rsp_phase, e.phase);
               if (rsp_elapsed !== e.elapsed) report("elapsed", rsp_elapsed, e.elapsed);
               if (rsp_hours !== e.hours) report("hours", rsp_hours, e.hours);
               if (rsp_minutes !== e.minutes) report("minutes", rsp_minutes, e.minutes);
               if (rsp_seconds !== e.seconds) report("seconds", rsp_seconds, e.seconds);
               if (rsp_tenths_shown !== e.tenths) report("tenths", rsp_tenths_shown, e.tenths);
               if (rsp_lap_average !== e.average) report("average", rsp_lap_average, e.average);
               if (rsp_lap_extreme !== e.extreme) report("extreme", rsp_lap_extreme, e.extreme);
               if (rsp_shows_minimum !== e.min_view)
                  report("shows_minimum", rsp_shows_minimum, e.min_view);
               if (rsp_resolution !== e.resolution)
                  report("resolution", rsp_resolution, e.resolution);
               if (rsp_trigger_level !== e.trigger)
                  report("trigger_level", rsp_trigger_level, e.trigger);
               if (rsp_sound_started !== e.by_sound)
                  report("sound_started", rsp_sound_started, e.by_sound);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HOLD:   hold_secs = csr_data;
               CSR_GUARD:  guard = csr_data;
               CSR_OFFSET: offset = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            step_display(req_mode, req_sample, d);
            display_q.push_back(d);
         end
      end
   end

endmodule

>>> dv/trigger_stopwatch_controller_core_tb.sv
`timescale 1ns / 100ps
module trigger_stopwatch_controller_core_tb;
   import tsc_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 300;
   localparam int PHASE_ITEMS = 365;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [1:0]  req_mode;
   logic [7:0]  req_sample;
   logic        rsp_valid, rsp_ready;
   logic [2:0]  rsp_phase;
   logic [23:0] rsp_elapsed, rsp_lap_average, rsp_lap_extreme;
   logic [7:0]  rsp_hours, rsp_trigger_level;
   logic [5:0]  rsp_minutes, rsp_seconds;
   logic [3:0]  rsp_tenths_shown;
   logic        rsp_shows_minimum, rsp_sound_started;
   logic [1:0]  rsp_resolution;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;
   int          errors;
   int          sent, received, idle_cycles, stall;
   bit          quiet;

   trigger_stopwatch_controller_core dut (.*);
   trigger_stopwatch_controller_core_checker chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      int wait_cycles;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall <= 0;
         received <= 0;
      end else if (rsp_valid && rsp_ready) begin
         received <= received + 1;
         wait_cycles = quiet ? 0 : $urandom_range(0, 7);
         stall <= wait_cycles;
         rsp_ready <= (wait_cycles == 0);
      end else if (stall > 0) begin
         stall <= stall - 1;
         rsp_ready <= (stall == 1);
      end else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[trigger_stopwatch_controller_core] ERROR");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   task automatic send(input logic [1:0] mode, input logic [7:0] smp);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0 && req_valid) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else if (gap > 0) repeat (gap) @(posedge clock);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic settle();
      @(posedge clock);
      req_valid <= 1'b0;
      while (received != sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_event();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) send(MODE_TICK, 8'($urandom));
      else if (r < 58) send(MODE_SHORT, 8'($urandom));
      else if (r < 72) send(MODE_LONG, 8'($urandom));
      else send(MODE_AUDIO, 8'($urandom));
   endtask

   initial begin
      logic [7:0] cfg[5][3];
      cfg = '{'{8'd0, 8'd0, 8'd0}, '{8'd1, 8'd2, 8'd255}, '{8'd2, 8'd255, 8'd128},
              '{8'd255, 8'd1, 8'd7}, '{8'd1, 8'd0, 8'd32}};
      sent = 0;
      quiet = 0;
      reset = 1'b1;
      req_valid = 1'b0; req_mode = MODE_TICK; req_sample = '0;
      csr_valid = 1'b0; csr_index = CSR_HOLD; csr_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk through every phase at reset settings
      send(MODE_SHORT, 8'h00);
      send(MODE_SHORT, 8'hFF);
      send(MODE_LONG, 8'h00);
      send(MODE_AUDIO, 8'd176);          // equal to trigger: no start
      send(MODE_AUDIO, 8'hFF);
      send(MODE_AUDIO, 8'hFF);           // inside guard time
      repeat (6) send(MODE_TICK, 8'h00);
      send(MODE_AUDIO, 8'hFF);
      send(MODE_SHORT, 8'h00);           // ignored in hold
      repeat (30) send(MODE_TICK, 8'h00);
      send(MODE_LONG, 8'h00);
      send(MODE_SHORT, 8'h00);
      repeat (3) send(MODE_TICK, 8'h00);
      send(MODE_SHORT, 8'h00);
      repeat (30) send(MODE_TICK, 8'h00);
      send(MODE_LONG, 8'h00);
      repeat (3) send(MODE_SHORT, 8'h00);
      send(MODE_LONG, 8'h00);
      send(MODE_SHORT, 8'h00);
      repeat (5) send(MODE_AUDIO, 8'hFF);
      repeat (5) send(MODE_AUDIO, 8'h00);
      repeat (30) send(MODE_TICK, 8'h00);
      send(MODE_SHORT, 8'h00);
      settle();
      csr_write(CSR_SPARE, 8'hA5);

      foreach (cfg[p]) begin
         csr_write(CSR_HOLD, cfg[p][0]);
         csr_write(CSR_GUARD, cfg[p][1]);
         csr_write(CSR_OFFSET, cfg[p][2]);
         quiet = (p == 2);
         repeat (PHASE_ITEMS) random_event();
         settle();
      end

      if (errors == 0 && received == sent)
         $display("[trigger_stopwatch_controller_core] OK");
      else
         $display("[trigger_stopwatch_controller_core] ERROR");
      $finish;
   end

endmodule
